>>> design/load_cell_trigger_detector_assert.svh
// Assertion macros shared by the load-cell trigger detector RTL.
// Expects clk and arst_n in the scope of every use.
`ifndef LOAD_CELL_TRIGGER_DETECTOR_ASSERT_SVH
`define LOAD_CELL_TRIGGER_DETECTOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LCTD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define LCTD_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define LCTD_ASSERT(lbl, prop, msg)
`define LCTD_NEVER(lbl, expr, msg)
`endif
`endif

>>> design/lctd_pkg.sv
// Types, constants and helper functions of the load-cell trigger detector.
// No dependencies; imported by every module of the block.
package lctd_pkg;

	typedef logic signed [23:0] sample_t;
	typedef logic signed [24:0] rate_t;
	typedef logic [23:0]        mag_t;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_ARM    = 1'b1
	} op_t;

	// Delay-line control from the pipeline to the window unit
	typedef struct packed {
		logic accept;  // new request enters s1, issue memory read
		logic commit;  // sample request leaves s1, write back
	} win_ctl_t;

	// Exponential average steps as shifts: 1/128 and 1/32
	localparam int unsigned SLOW_SH = 7;
	localparam int unsigned FAST_SH = 5;

	// avg + (s - avg) / 2^sh, quotient truncated toward zero
	function automatic sample_t ema_step(sample_t avg, sample_t s, int unsigned sh);
		logic signed [24:0] d;
		logic signed [24:0] q;
		logic signed [24:0] r;
		d = {s[23], s} - {avg[23], avg};
		if (d[24]) begin
			q = (d + ((25'sd1 <<< sh) - 25'sd1)) >>> sh;
		end else begin
			q = d >>> sh;
		end
		r = {avg[23], avg} + q;
		return r[23:0];
	endfunction

endpackage

>>> design/load_cell_trigger_detector.sv
// Top level of the load-cell trigger detector: stream ports, pipeline, averages.
// Depends on lctd_pkg, lctd_window, lctd_avg_div, lctd_trigger, assertion header.
`include "load_cell_trigger_detector_assert.svh"

// Load-cell trigger detector. Each request on the s_ stream is either a signed
// 24-bit ADC sample (s_tuser = 0) or an arm-homing command (s_tuser = 1); every
// request yields exactly one result on the m_ stream. A result carries the
// WINDOW-sample moving average (truncated toward zero), the latest raw sample,
// the rate (fast minus slow exponential average, steps 1/32 and 1/128), the
// trigger level (|rate| > sensitivity) and the magnitude of the last homing
// capture (reference minus the sample on which the trigger rose while armed).
// Throughput is one request per clock while m_tready does not stall the output.
// A request passes s1, s2 and then the output register: s1 waits on the
// registered delay-line memory read and updates the window sum and averages,
// s2 evaluates the trigger and the reciprocal-multiply divide. Back-to-back
// samples always touch different delay-line entries, except with a one-entry
// window, where write data is forwarded. Delay-line entries carry valid bits
// cleared at reset, so no clearing pass is needed and requests are taken from
// the first cycle after reset. sensitivity is written on the cfg_ channel,
// always ready, and should only change while no request is in flight.
module load_cell_trigger_detector #(
	parameter int WINDOW = 50
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [23:0]   s_tdata,   // [23:0] sample
	input  logic          s_tuser,   // [0] operation
	output logic          m_tvalid,
	input  logic          m_tready,
	// [23:0] average, [47:24] latest_raw, [72:48] rate, [73] trigger_level,
	// [97:74] diff_magnitude, [103:98] zero
	output logic [103:0]  m_tdata,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [23:0]   cfg_data   // sensitivity
);
	import lctd_pkg::*;

	localparam int SUM_W = 25 + $clog2(WINDOW);

	// stage handshake
	logic adv_out;   // output register free or draining
	logic s2_free;   // s2 can take a request
	logic accept;
	logic adv1;
	logic adv2;
	logic commit;

	// s1
	logic    v_s1;
	op_t     op_s1;
	sample_t sample_s1;

	// s2
	logic    v_s2;
	op_t     op_s2;
	sample_t latest_s2;
	sample_t slow_s2;
	sample_t fast_s2;
	logic signed [SUM_W-1:0] sum_s2;

	// block state outside the memory
	mag_t    sens_q;
	sample_t slow_q;
	sample_t fast_q;
	sample_t last_q;
	sample_t slow_nx;
	sample_t fast_nx;

	win_ctl_t                win_ctl;
	logic signed [SUM_W-1:0] sum_upd;

	// results
	sample_t average;
	rate_t   rate;
	logic    trig_level;
	mag_t    diff_mag;

	logic    m_tvalid_q;
	sample_t avg_q;
	sample_t raw_q;
	rate_t   rate_q;
	logic    trig_q;
	mag_t    dmag_q;

	assign adv_out  = !m_tvalid_q || m_tready;
	assign s2_free  = !v_s2 || adv_out;
	assign s_tready = !v_s1 || s2_free;
	assign accept   = s_tvalid && s_tready;
	assign adv1     = v_s1 && s2_free;
	assign adv2     = v_s2 && adv_out;
	assign commit   = adv1 && (op_s1 == OP_SAMPLE);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q <= '0;
		end else if (cfg_valid) begin
			sens_q <= cfg_data;
		end
	end

	// s1: request waits here for the delay-line read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= op_t'(s_tuser);
			sample_s1 <= s_tdata;
		end
	end

	assign win_ctl.accept = accept;
	assign win_ctl.commit = commit;

	lctd_window #(
		.WINDOW (WINDOW)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (win_ctl),
		.op      (op_s1),
		.sample  (sample_s1),
		.sum_upd (sum_upd)
	);

	assign slow_nx = ema_step(slow_q, sample_s1, SLOW_SH);
	assign fast_nx = ema_step(fast_q, sample_s1, FAST_SH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_q <= '0;
			fast_q <= '0;
			last_q <= '0;
		end else if (commit) begin
			slow_q <= slow_nx;
			fast_q <= fast_nx;
			last_q <= sample_s1;
		end
	end

	// s2: trigger evaluation and divide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			op_s2  <= op_s1;
			sum_s2 <= sum_upd;
			if (op_s1 == OP_SAMPLE) begin
				latest_s2 <= sample_s1;
				slow_s2   <= slow_nx;
				fast_s2   <= fast_nx;
			end else begin
				latest_s2 <= last_q;
				slow_s2   <= slow_q;
				fast_s2   <= fast_q;
			end
		end
	end

	lctd_avg_div #(
		.WINDOW (WINDOW)
	) u_avg_div (
		.sum     (sum_s2),
		.average (average)
	);

	lctd_trigger u_trigger (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (adv2),
		.op          (op_s2),
		.latest      (latest_s2),
		.slow        (slow_s2),
		.fast        (fast_s2),
		.sensitivity (sens_q),
		.rate        (rate),
		.trig_level  (trig_level),
		.diff_mag    (diff_mag)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv_out) begin
			m_tvalid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			avg_q  <= average;
			raw_q  <= latest_s2;
			rate_q <= rate;
			trig_q <= trig_level;
			dmag_q <= diff_mag;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, dmag_q, trig_q, rate_q, raw_q, avg_q};

	`LCTD_ASSERT(a_stall_cause, !s_tready |-> (v_s2 && m_tvalid_q && !m_tready), "input stalled with room")
	`LCTD_ASSERT(a_out_fill, (v_s2 && !m_tvalid_q) |=> m_tvalid_q, "s2 result not moved to output")

endmodule

>>> design/lctd_window.sv
// Delay-line memory and running window sum of the load-cell trigger detector.
// Depends on lctd_pkg and the assertion macro header.
`include "load_cell_trigger_detector_assert.svh"

module lctd_window #(
	parameter int WINDOW = 50
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  lctd_pkg::win_ctl_t                      ctl,
	input  lctd_pkg::op_t                           op,      // op of the request in s1
	input  lctd_pkg::sample_t                       sample,  // sample of the request in s1
	output logic signed [25+$clog2(WINDOW)-1:0]     sum_upd  // window sum after this request
);
	import lctd_pkg::*;

	localparam int SUM_W = 25 + $clog2(WINDOW);
	localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	sample_t            mem [WINDOW];
	logic [WINDOW-1:0]  vld_q;      // entry written since reset, else reads as zero
	logic [PTR_W-1:0]   wp_q;
	logic [PTR_W-1:0]   wp_inc;
	logic [PTR_W-1:0]   rd_addr;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] sum_calc;

	sample_t rd_old_s1;
	logic    rd_vld_s1;
	logic    fwd_s1;
	sample_t fwd_data_s1;
	sample_t old;

	assign wp_inc  = (wp_q == PTR_W'(WINDOW - 1)) ? '0 : wp_q + 1'b1;
	// a request entering while the previous one writes back reads the next slot
	assign rd_addr = ctl.commit ? wp_inc : wp_q;

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			rd_old_s1   <= mem[rd_addr];
			fwd_data_s1 <= sample;
		end
		if (ctl.commit) begin
			mem[wp_q] <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			vld_q     <= '0;
			sum_q     <= '0;
			rd_vld_s1 <= 1'b0;
			fwd_s1    <= 1'b0;
		end else begin
			if (ctl.accept) begin
				rd_vld_s1 <= vld_q[rd_addr];
				fwd_s1    <= ctl.commit && (rd_addr == wp_q);
			end
			if (ctl.commit) begin
				wp_q        <= wp_inc;
				vld_q[wp_q] <= 1'b1;
				sum_q       <= sum_calc;
			end
		end
	end

	// same-entry hazard only arises for a one-entry window
	assign old      = fwd_s1 ? fwd_data_s1 : (rd_vld_s1 ? rd_old_s1 : '0);
	assign sum_calc = sum_q + SUM_W'(sample) - SUM_W'(old);
	assign sum_upd  = (op == OP_SAMPLE) ? sum_calc : sum_q;

	`LCTD_NEVER(a_wp_range, wp_q > PTR_W'(WINDOW - 1), "write pointer beyond window")

endmodule

>>> design/lctd_avg_div.sv
// Window sum divided by WINDOW, truncated toward zero, by reciprocal multiply.
// Depends on lctd_pkg.
module lctd_avg_div #(
	parameter int WINDOW = 50
) (
	input  logic signed [25+$clog2(WINDOW)-1:0] sum,
	output lctd_pkg::sample_t                   average
);
	import lctd_pkg::*;

	localparam int WL    = $clog2(WINDOW);
	localparam int SUM_W = 25 + WL;
	localparam int MAG_W = 24 + WL;
	localparam int SH    = MAG_W + WL;
	localparam int M_W   = MAG_W + 1;
	localparam longint unsigned RECIP = ((64'd1 << SH) + WINDOW - 1) / WINDOW;

	logic [M_W-1:0]       recip;
	logic [SUM_W-1:0]     neg_sum;
	logic [MAG_W-1:0]     mag;
	logic [MAG_W+M_W-1:0] prod;
	logic [23:0]          quot;

	assign recip   = M_W'(RECIP);
	assign neg_sum = -sum;
	assign mag     = sum[SUM_W-1] ? neg_sum[MAG_W-1:0] : sum[MAG_W-1:0];
	assign prod    = (MAG_W+M_W)'(mag) * (MAG_W+M_W)'(recip);
	assign quot    = 24'(prod >> SH);
	assign average = sum[SUM_W-1] ? -quot : quot;

endmodule

>>> design/lctd_trigger.sv
// Rate threshold, trigger level and homing capture of the trigger detector.
// Depends on lctd_pkg and the assertion macro header.
`include "load_cell_trigger_detector_assert.svh"

module lctd_trigger (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,          // request leaves s2
	input  lctd_pkg::op_t     op,
	input  lctd_pkg::sample_t latest,      // last raw sample after this request
	input  lctd_pkg::sample_t slow,
	input  lctd_pkg::sample_t fast,
	input  lctd_pkg::mag_t    sensitivity,
	output lctd_pkg::rate_t   rate,
	output logic              trig_level,
	output lctd_pkg::mag_t    diff_mag
);
	import lctd_pkg::*;

	logic    trig_q;
	logic    armed_q;
	sample_t ref_q;
	mag_t    dmag_q;

	logic [24:0] rate_mag;
	logic        above;
	logic        is_sample;
	logic        capture;
	rate_t       diffv;
	rate_t       diff_neg;
	mag_t        dmag_next;

	assign rate      = {fast[23], fast} - {slow[23], slow};
	assign rate_mag  = rate[24] ? 25'(-rate) : 25'(rate);
	assign above     = rate_mag > {1'b0, sensitivity};
	assign is_sample = go && (op == OP_SAMPLE);
	assign capture   = is_sample && above && !trig_q && armed_q;

	assign diffv     = {ref_q[23], ref_q} - {latest[23], latest};
	assign diff_neg  = -diffv;
	assign dmag_next = capture ? (diffv[24] ? diff_neg[23:0] : diffv[23:0]) : dmag_q;
	assign diff_mag  = dmag_next;

	always_comb begin
		trig_level = trig_q;
		if (is_sample) begin
			trig_level = above;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_q  <= 1'b0;
			armed_q <= 1'b0;
			ref_q   <= '0;
			dmag_q  <= '0;
		end else begin
			trig_q <= trig_level;
			dmag_q <= dmag_next;
			if (go && (op == OP_ARM)) begin
				armed_q <= 1'b1;
				ref_q   <= latest;
			end else if (capture) begin
				armed_q <= 1'b0;
			end
		end
	end

	`LCTD_ASSERT(a_disarm_on_rise, $fell(armed_q) |-> $rose(trig_q), "disarmed without trigger rise")
	`LCTD_ASSERT(a_rise_needs_go, $rose(trig_q) |-> $past(go), "trigger moved without a request")

endmodule
